// ----- design/lua_source_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// Lua source tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LUA_SOURCE_TOKENIZER_DEFINES_SVH
`define LUA_SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define LST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lst_pkg.sv -----
// ----------------------------------------------------------------------------
// Lua source tokenizer package
// Token kinds, scanner modes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int OFFSET_BITS_DEF       = 24;
  localparam int MAX_BRACKET_LEVEL_DEF = 255;
  localparam int LINE_BITS             = 24;
  localparam int KIND_BITS             = 6;
  localparam int ERR_BITS              = 3;

  localparam logic [KIND_BITS-1:0] K_SINGLE   = 6'd0;
  localparam logic [KIND_BITS-1:0] K_NAME     = 6'd1;
  localparam logic [KIND_BITS-1:0] K_KW0      = 6'd2;
  localparam logic [KIND_BITS-1:0] K_IDIV     = 6'd24;
  localparam logic [KIND_BITS-1:0] K_CONCAT   = 6'd25;
  localparam logic [KIND_BITS-1:0] K_DOTS     = 6'd26;
  localparam logic [KIND_BITS-1:0] K_EQ       = 6'd27;
  localparam logic [KIND_BITS-1:0] K_GE       = 6'd28;
  localparam logic [KIND_BITS-1:0] K_LE       = 6'd29;
  localparam logic [KIND_BITS-1:0] K_NE       = 6'd30;
  localparam logic [KIND_BITS-1:0] K_SHL      = 6'd31;
  localparam logic [KIND_BITS-1:0] K_SHR      = 6'd32;
  localparam logic [KIND_BITS-1:0] K_DBCOLON  = 6'd33;
  localparam logic [KIND_BITS-1:0] K_STRING   = 6'd34;
  localparam logic [KIND_BITS-1:0] K_LCOMMENT = 6'd35;
  localparam logic [KIND_BITS-1:0] K_SCOMMENT = 6'd36;
  localparam logic [KIND_BITS-1:0] K_SHEBANG  = 6'd37;
  localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd38;
  localparam logic [KIND_BITS-1:0] K_END      = 6'd39;

  localparam logic [ERR_BITS-1:0] E_NONE       = 3'd0;
  localparam logic [ERR_BITS-1:0] E_BAD_DELIM  = 3'd1;
  localparam logic [ERR_BITS-1:0] E_LONG_OPEN  = 3'd2;
  localparam logic [ERR_BITS-1:0] E_STR_OPEN   = 3'd3;
  localparam logic [ERR_BITS-1:0] E_BAD_SUFFIX = 3'd4;

  typedef enum logic [4:0] {
    M_IDLE, M_NAME, M_OP2, M_DOT, M_DOT2, M_DASH, M_DASH2, M_CMT_EQ,
    M_SHORT, M_OPEN_EQ, M_LONG_FIRST, M_LONG_BODY, M_LONG_CLOSE,
    M_STR, M_STR_ESC, M_STR_Z, M_NUM0, M_NUM, M_NUM_SIGN, M_NUM_U, M_NUM_UL
  } mode_t;

  localparam int KW_COUNT = 22;
  localparam logic [63:0] KW_WORD [KW_COUNT] = '{
    "and", "break", "do", "else", "elseif", "end", "false", "for",
    "function", "goto", "if", "in", "local", "nil", "not", "or",
    "repeat", "return", "then", "true", "until", "while"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3,
    4'd8, 4'd4, 4'd2, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2,
    4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
  };

  function automatic logic is_nl(logic [7:0] c);
    return c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_lead(logic [7:0] c);
    return is_alpha(c) || c == "_" || c[7];
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_lead(c) || is_digit(c);
  endfunction

  function automatic logic is_hspace(logic [7:0] c);
    return c == 8'h20 || c == 8'h0C || c == 8'h09 || c == 8'h0B;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return is_hspace(c) || is_nl(c);
  endfunction

  function automatic logic [KIND_BITS-1:0] pair_kind(logic [7:0] lead, logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    k = K_SINGLE;
    if (lead == "=" && c == "=") k = K_EQ;
    else if (lead == "<" && c == "=") k = K_LE;
    else if (lead == "<" && c == "<") k = K_SHL;
    else if (lead == ">" && c == "=") k = K_GE;
    else if (lead == ">" && c == ">") k = K_SHR;
    else if (lead == "/" && c == "/") k = K_IDIV;
    else if (lead == "~" && c == "=") k = K_NE;
    else if (lead == ":" && c == ":") k = K_DBCOLON;
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] kw_kind(logic [63:0] w, logic [3:0] len);
    logic [KIND_BITS-1:0] k;
    k = K_NAME;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len == KW_LEN[i] && w == KW_WORD[i]) k = K_KW0 + KIND_BITS'(i);
    end
    return k;
  endfunction

endpackage

// ----- design/lua_source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Lua source tokenizer
// Scans Lua source a byte per transaction and emits classified tokens.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid, in_stall  | text_byte, is_end
//  out     | source    | out_valid, out_stall| token fields, line_count, last_of_run
//
// One byte is taken per cycle while in_stall is low; the scanner state
// updates in the same cycle through up to three chained passes of the mode
// logic. Results go to a two-entry queue; a byte that yields two tokens
// holds the input while the queue drains.
// Reset clears the scanner and the queue. After an error no result is
// produced until reset. out_stall backs up into in_stall.
`include "lua_source_tokenizer_defines.svh"

module lua_source_tokenizer #(
  parameter int OFFSET_BITS       = lst_pkg::OFFSET_BITS_DEF,
  parameter int MAX_BRACKET_LEVEL = lst_pkg::MAX_BRACKET_LEVEL_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               text_byte,
  input  logic                     is_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [5:0]               token_kind,
  output logic [7:0]               token_char,
  output logic [OFFSET_BITS-1:0]   start_offset,
  output logic [OFFSET_BITS-1:0]   end_offset,
  output logic [2:0]               error_code,
  output logic [23:0]              line_count,
  output logic                     last_of_run
);
  import lst_pkg::*;

  typedef struct packed {
    mode_t                  mode;
    logic [KIND_BITS-1:0]   pend;
    logic [OFFSET_BITS-1:0] tstart;
    logic [OFFSET_BITS-1:0] tlast;
    logic [OFFSET_BITS-1:0] pos;
    logic [LINE_BITS-1:0]   lines;
    logic [7:0]             open;
    logic [8:0]             close;
    logic [63:0]            win;
    logic [3:0]             wlen;
    logic [7:0]             pbreak;
    logic [7:0]             qc;
    logic                   halted;
    logic                   seen;
    logic                   hex;
  } lx_t;

  typedef struct packed {
    logic                   v;
    logic [KIND_BITS-1:0]   kind;
    logic [7:0]             ch;
    logic [OFFSET_BITS-1:0] s;
    logic [OFFSET_BITS-1:0] e;
    logic [ERR_BITS-1:0]    err;
    logic [LINE_BITS-1:0]   lines;
    logic                   last;
  } res_t;

  typedef struct packed {
    lx_t  st;
    logic used;
    res_t r;
  } pass_t;

  localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [7:0]             OPEN_MAX = 8'(MAX_BRACKET_LEVEL);
  localparam logic [8:0]             CLOSE_MAX = 9'(MAX_BRACKET_LEVEL);

  function automatic lx_t clear_state();
    lx_t z;
    z = '0;
    z.mode = M_IDLE;
    return z;
  endfunction

  function automatic pass_t emit(pass_t o, logic [KIND_BITS-1:0] kind, logic [7:0] ch,
                                 logic [OFFSET_BITS-1:0] s, logic [OFFSET_BITS-1:0] e,
                                 logic [ERR_BITS-1:0] err);
    pass_t q;
    q = o;
    q.r.v     = 1'b1;
    q.r.kind  = kind;
    q.r.ch    = ch;
    q.r.s     = s;
    q.r.e     = e;
    q.r.err   = err;
    q.r.lines = o.st.lines;
    q.r.last  = 1'b0;
    if (kind != K_LCOMMENT && kind != K_SCOMMENT && kind != K_SHEBANG && kind != K_END)
      q.st.seen = 1'b1;
    if (err != E_NONE) q.st.halted = 1'b1;
    return q;
  endfunction

  function automatic pass_t finish(pass_t o, logic [KIND_BITS-1:0] kind, logic [7:0] ch);
    pass_t q;
    q = emit(o, kind, ch, o.st.tstart, o.st.tlast, E_NONE);
    q.st.mode = M_IDLE;
    return q;
  endfunction

  function automatic pass_t fail(pass_t o, logic [KIND_BITS-1:0] kind,
                                 logic [ERR_BITS-1:0] code);
    pass_t q;
    q = emit(o, kind, 8'd0, o.st.tstart, o.st.tlast, code);
    q.st.mode = M_IDLE;
    return q;
  endfunction

  function automatic lx_t line_break(lx_t s, logic [7:0] c);
    lx_t q;
    q = s;
    if (s.lines != LINE_MAX) q.lines = s.lines + 1'b1;
    q.pbreak = c;
    return q;
  endfunction

  // One pass of the scanner; used low offers the byte again.
  function automatic pass_t run(lx_t s, logic [7:0] c, logic e, logic [OFFSET_BITS-1:0] p);
    pass_t                o;
    logic [KIND_BITS-1:0] k;
    logic [7:0]           ek;
    o = '0;
    o.st = s;
    o.used = 1'b1;
    k = K_SINGLE;
    ek = 8'd0;
    unique case (s.mode)
      M_IDLE: begin
        if (e) begin
          o = emit(o, K_END, 8'd0, p, p, E_NONE);
          o.st = clear_state();
        end else begin
          o.st.tstart = p;
          o.st.tlast = p;
          if (is_nl(c)) o.st = line_break(o.st, c);
          else if (is_hspace(c)) o.st.mode = M_IDLE;
          else if (c == "-") o.st.mode = M_DASH;
          else if (c == "[") begin
            o.st.open = 8'd0;
            o.st.mode = M_OPEN_EQ;
          end else if (pair_kind(c, "=") != K_SINGLE || c == "/" || c == ":") begin
            o.st.qc = c;
            o.st.mode = M_OP2;
          end else if (c == 8'h22 || c == 8'h27) begin
            o.st.qc = c;
            o.st.mode = M_STR;
          end else if (c == ".") o.st.mode = M_DOT;
          else if (c == "#") begin
            if (s.lines == '0 && !s.seen) begin
              o.st.pend = K_SHEBANG;
              o.st.mode = M_SHORT;
            end else o = finish(o, K_SINGLE, c);
          end else if (is_digit(c)) begin
            o.st.hex = 1'b0;
            o.st.mode = (c == "0") ? M_NUM0 : M_NUM;
          end else if (is_lead(c)) begin
            o.st.win = {56'd0, c};
            o.st.wlen = 4'd1;
            o.st.mode = M_NAME;
          end else o = finish(o, K_SINGLE, c);
        end
      end
      M_NAME: begin
        if (!e && is_word(c)) begin
          o.st.tlast = p;
          o.st.win = {s.win[55:0], c};
          if (s.wlen < 4'd9) o.st.wlen = s.wlen + 4'd1;
        end else begin
          o = finish(o, (s.wlen > 4'd8) ? K_NAME : kw_kind(s.win, s.wlen), 8'd0);
          o.used = 1'b0;
        end
      end
      M_OP2: begin
        k = e ? K_SINGLE : pair_kind(s.qc, c);
        if (k != K_SINGLE) begin
          o.st.tlast = p;
          o = finish(o, k, 8'd0);
        end else begin
          o = finish(o, K_SINGLE, s.qc);
          o.used = 1'b0;
        end
      end
      M_DOT: begin
        if (!e && c == ".") begin
          o.st.tlast = p;
          o.st.mode = M_DOT2;
        end else if (!e && is_digit(c)) begin
          o.st.tlast = p;
          o.st.hex = 1'b0;
          o.st.mode = (c == "0") ? M_NUM0 : M_NUM;
        end else begin
          o = finish(o, K_SINGLE, ".");
          o.used = 1'b0;
        end
      end
      M_DOT2: begin
        if (!e && c == ".") begin
          o.st.tlast = p;
          o = finish(o, K_DOTS, 8'd0);
        end else begin
          o = finish(o, K_CONCAT, 8'd0);
          o.used = 1'b0;
        end
      end
      M_DASH: begin
        if (!e && c == "-") begin
          o.st.tlast = p;
          o.st.mode = M_DASH2;
        end else begin
          o = finish(o, K_SINGLE, "-");
          o.used = 1'b0;
        end
      end
      M_DASH2: begin
        if (!e && c == "[") begin
          o.st.tlast = p;
          o.st.open = 8'd0;
          o.st.mode = M_CMT_EQ;
        end else begin
          o.st.pend = K_SCOMMENT;
          o.st.mode = M_SHORT;
          o.used = 1'b0;
        end
      end
      M_CMT_EQ, M_OPEN_EQ: begin
        k = (s.mode == M_CMT_EQ) ? K_LCOMMENT : K_STRING;
        if (!e && c == "=") begin
          if (s.open >= OPEN_MAX) o = fail(o, k, E_BAD_DELIM);
          else begin
            o.st.open = s.open + 8'd1;
            o.st.tlast = p;
          end
        end else if (!e && c == "[") begin
          o.st.tlast = p;
          o.st.pend = k;
          o.st.mode = M_LONG_FIRST;
        end else if (k == K_LCOMMENT) begin
          o.st.pend = K_SCOMMENT;
          o.st.mode = M_SHORT;
          o.used = 1'b0;
        end else if (s.open == 8'd0) begin
          o = finish(o, K_SINGLE, "[");
          o.used = 1'b0;
        end else o = fail(o, K_STRING, E_BAD_DELIM);
      end
      M_SHORT: begin
        if (e || is_nl(c)) begin
          o = finish(o, s.pend, 8'd0);
          o.used = 1'b0;
        end else o.st.tlast = p;
      end
      M_LONG_FIRST: begin
        o.st.mode = M_LONG_BODY;
        if (!e && is_nl(c)) o.st = line_break(o.st, c);
        else o.used = 1'b0;
      end
      M_LONG_BODY: begin
        if (e) o = fail(o, s.pend, E_LONG_OPEN);
        else begin
          o.st.tlast = p;
          if (c == "]") begin
            o.st.close = 9'd0;
            o.st.mode = M_LONG_CLOSE;
          end else if (is_nl(c)) o.st = line_break(o.st, c);
        end
      end
      M_LONG_CLOSE: begin
        if (e) o = fail(o, s.pend, E_LONG_OPEN);
        else if (c == "=") begin
          o.st.tlast = p;
          if (s.close <= CLOSE_MAX) o.st.close = s.close + 9'd1;
        end else if (c == "]") begin
          o.st.tlast = p;
          if (s.close == {1'b0, s.open}) o = finish(o, s.pend, 8'd0);
          else o.st.close = 9'd0;
        end else begin
          o.st.mode = M_LONG_BODY;
          o.used = 1'b0;
        end
      end
      M_STR: begin
        if (e || is_nl(c)) o = fail(o, K_STRING, E_STR_OPEN);
        else begin
          o.st.tlast = p;
          if (c == s.qc) o = finish(o, K_STRING, 8'd0);
          else if (c == 8'h5C) o.st.mode = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        if (e) o = fail(o, K_STRING, E_STR_OPEN);
        else if (is_nl(c)) begin
          o.st = line_break(o.st, c);
          o.st.mode = M_STR;
        end else begin
          o.st.tlast = p;
          o.st.mode = (c == "z") ? M_STR_Z : M_STR;
        end
      end
      M_STR_Z: begin
        if (!e && is_space(c)) begin
          if (is_nl(c)) o.st = line_break(o.st, c);
          else o.st.tlast = p;
        end else begin
          o.st.mode = M_STR;
          o.used = 1'b0;
        end
      end
      M_NUM0: begin
        o.st.mode = M_NUM;
        if (!e && (c == "x" || c == "X")) begin
          o.st.tlast = p;
          o.st.hex = 1'b1;
        end else o.used = 1'b0;
      end
      M_NUM: begin
        ek = s.hex ? "P" : "E";
        if (e) begin
          o = finish(o, K_NUMBER, 8'd0);
          o.used = 1'b0;
        end else if (c == ek || c == (ek + 8'd32)) begin
          o.st.tlast = p;
          o.st.mode = M_NUM_SIGN;
        end else if (is_xdigit(c) || c == ".") o.st.tlast = p;
        else if (is_alpha(c)) begin
          o.st.tlast = p;
          if (c == "U") o.st.mode = M_NUM_U;
          else o = finish(o, K_NUMBER, 8'd0);
        end else begin
          o = finish(o, K_NUMBER, 8'd0);
          o.used = 1'b0;
        end
      end
      M_NUM_SIGN: begin
        o.st.mode = M_NUM;
        if (!e && (c == "-" || c == "+")) o.st.tlast = p;
        else o.used = 1'b0;
      end
      M_NUM_U, M_NUM_UL: begin
        if (e || c != "L") o = fail(o, K_NUMBER, E_BAD_SUFFIX);
        else begin
          o.st.tlast = p;
          if (s.mode == M_NUM_U) o.st.mode = M_NUM_UL;
          else o = finish(o, K_NUMBER, 8'd0);
        end
      end
      default: begin
        o.st.mode = M_IDLE;
        o.used = 1'b0;
      end
    endcase
    return o;
  endfunction

  lx_t        lx, lx_next;
  res_t [1:0] q, q_next;
  logic [1:0] cnt, cnt_next;
  res_t       r0, r1;
  logic [1:0] n_res;
  lx_t        pre;
  logic       skip;
  pass_t      p1, p2, p3;
  logic       in_take, out_take;

  assign out_take = out_valid && !out_stall;
  assign in_stall = !(cnt == 2'd0 || (cnt == 2'd1 && out_take));
  assign in_take  = in_valid && !in_stall;

  // Scanner update for the byte on the input ports.
  always_comb begin
    pre  = lx;
    skip = 1'b0;
    if (lx.pbreak != 8'd0) begin
      pre.pbreak = 8'd0;
      // second half of a CRLF or LFCR pair
      if (!is_end && is_nl(text_byte) && text_byte != lx.pbreak) skip = 1'b1;
    end
    p1 = run(pre, text_byte, is_end, lx.pos);
    p2 = p1;
    p2.r = '0;
    if (!p1.used && !p1.st.halted) p2 = run(p1.st, text_byte, is_end, lx.pos);
    p3 = p2;
    p3.r = '0;
    if (!p1.used && !p2.used && !p2.st.halted) p3 = run(p2.st, text_byte, is_end, lx.pos);

    r0 = p1.r.v ? p1.r : (p2.r.v ? p2.r : p3.r);
    r1 = (p1.r.v && p2.r.v) ? p2.r : p3.r;
    if (!(p1.r.v || p2.r.v)) r1 = '0;
    n_res = {1'b0, p1.r.v} + {1'b0, p2.r.v} + {1'b0, p3.r.v};
    if (n_res == 2'd1) r0.last = 1'b1;
    if (n_res == 2'd2) r1.last = 1'b1;

    lx_next = lx;
    if (in_take && !lx.halted) begin
      if (skip) begin
        lx_next = pre;
        n_res = 2'd0;
      end else lx_next = p3.st;
      if (!is_end && !lx_next.halted && lx_next.pos != POS_MAX)
        lx_next.pos = lx_next.pos + 1'b1;
    end
    if (!in_take || lx.halted) n_res = 2'd0;
  end

  // Result queue: load on a transaction, shift on a pop.
  always_comb begin
    q_next   = q;
    cnt_next = cnt;
    if (in_take) begin
      q_next[0] = r0;
      q_next[1] = r1;
      cnt_next  = n_res;
    end else if (out_take) begin
      q_next[0] = q[1];
      cnt_next  = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lx  <= clear_state();
      cnt <= 2'd0;
    end else begin
      lx  <= lx_next;
      cnt <= cnt_next;
    end
    q <= q_next;
  end

  assign out_valid    = cnt != 2'd0;
  assign token_kind   = q[0].kind;
  assign token_char   = q[0].ch;
  assign start_offset = q[0].s;
  assign end_offset   = q[0].e;
  assign error_code   = q[0].err;
  assign line_count   = q[0].lines;
  assign last_of_run  = q[0].last;

  `LST_ASSERT_NOW(a_full_stalls, cnt == 2'd2, in_stall, "queue full but input open")
  `LST_ASSERT_NOW(a_pair_order, cnt == 2'd2, !q[0].last && q[1].last,
                  "two-token run has wrong last marks")
  `LST_ASSERT_NEXT(a_halt_silent, lx.halted && in_take, cnt == 2'd0,
                   "result after error halt")
  `LST_ASSERT_NEXT(a_err_halts, in_take && n_res != 2'd0 && r0.err != E_NONE,
                   lx.halted, "error did not halt scanner")

endmodule
